@@ rtl/tcw_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and codes of the text console cell writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = CHAR_W + ATTR_W;
  localparam int KIND_W = 2;

  localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_NULL      = 8'h00;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;

  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_SCROLL,
    ST_PUT,
    ST_CLEAR,
    ST_RESULT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_BACKSPACE,
    OP_NEWLINE,
    OP_WRAP_PUT,
    OP_PUT,
    OP_SCROLL_BEGIN,
    OP_SCROLL_STEP,
    OP_FILL_BEGIN,
    OP_FILL_STEP,
    OP_INIT_STEP
  } op_t;

  typedef struct packed {
    op_t  op;
    logic latch;
    logic load_out;
  } tcw_cmd_t;

  typedef struct packed {
    logic is_put;
    logic is_clear;
    logic is_bs;
    logic is_nl;
    logic is_null;
    logic cursor_zero;
    logic col_last;
    logic line_lt_rows;
    logic fill_last;
    logic scroll_last;
    logic out_free;
  } tcw_status_t;

endpackage
`default_nettype wire

@@ rtl/tcw_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ram
// Generic memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

@@ rtl/tcw_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer: decodes each item and steps the datapath through sweeps.
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire tcw_pkg::tcw_status_t sts,
  output tcw_pkg::tcw_cmd_t        cmd
);

  import tcw_pkg::*;

  state_t state_r;
  state_t state_nxt;
  op_t    decode_op;
  logic   latch;

  always_comb begin
    decode_op = OP_NONE;
    if (sts.is_put) begin
      if (sts.is_bs) begin
        decode_op = sts.cursor_zero ? OP_NONE : OP_BACKSPACE;
      end else if (sts.is_nl) begin
        decode_op = sts.line_lt_rows ? OP_NEWLINE : OP_SCROLL_BEGIN;
      end else if (!sts.is_null) begin
        if (sts.col_last) begin
          decode_op = sts.line_lt_rows ? OP_WRAP_PUT : OP_SCROLL_BEGIN;
        end else begin
          decode_op = OP_PUT;
        end
      end
    end else if (sts.is_clear) begin
      decode_op = OP_FILL_BEGIN;
    end
  end

  always_comb begin
    case (state_r)
      ST_IDLE:   in_tready = 1'b1;
      ST_RESULT: in_tready = sts.out_free;
      default:   in_tready = 1'b0;
    endcase
  end

  assign latch = in_tready && in_tvalid;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (sts.fill_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (latch) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        case (decode_op)
          OP_SCROLL_BEGIN: state_nxt = ST_SCROLL;
          OP_FILL_BEGIN:   state_nxt = ST_CLEAR;
          default:         state_nxt = ST_RESULT;
        endcase
      end
      ST_SCROLL: begin
        if (sts.scroll_last) state_nxt = sts.is_nl ? ST_RESULT : ST_PUT;
      end
      ST_PUT: begin
        state_nxt = ST_RESULT;
      end
      ST_CLEAR: begin
        if (sts.fill_last) state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts.out_free) state_nxt = in_tvalid ? ST_DECODE : ST_IDLE;
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  // outputs
  always_comb begin
    cmd.op       = OP_NONE;
    cmd.latch    = latch;
    cmd.load_out = 1'b0;
    case (state_r)
      ST_INIT:   cmd.op = OP_INIT_STEP;
      ST_DECODE: cmd.op = decode_op;
      ST_SCROLL: cmd.op = OP_SCROLL_STEP;
      ST_PUT:    cmd.op = OP_PUT;
      ST_CLEAR:  cmd.op = OP_FILL_STEP;
      ST_RESULT: cmd.load_out = sts.out_free;
      default:   cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/tcw_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_datapath
// Cell store, cursor, column and line registers, sweep counter, result stage.
// ----------------------------------------------------------------------------
module tcw_datapath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  localparam int CELLS  = COLUMNS * ROWS,
  localparam int AW     = $clog2(CELLS),
  localparam int LW     = $clog2(ROWS + 1),
  localparam int OUT_DW = ((AW + LW + 17) + 7) / 8 * 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire tcw_pkg::tcw_cmd_t           cmd,
  output tcw_pkg::tcw_status_t             sts,
  input  wire logic [tcw_pkg::KIND_W-1:0]  in_kind,
  input  wire logic [tcw_pkg::CHAR_W-1:0]  in_char,
  input  wire logic [AW-1:0]               in_addr,
  input  wire logic                        cfg_we,
  input  wire logic [tcw_pkg::ATTR_W-1:0]  cfg_attr,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [OUT_DW-1:0]                out_tdata
);

  import tcw_pkg::*;

  localparam int CW = $clog2(COLUMNS);
  localparam int SW = $clog2(CELLS + 1);
  localparam logic [AW-1:0] LAST_ROW = AW'(CELLS - COLUMNS);
  localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);

  logic [KIND_W-1:0] kind_r,   kind_nxt;
  logic [CHAR_W-1:0] ch_r,     ch_nxt;
  logic [AW-1:0]     addr_r,   addr_nxt;
  logic [AW-1:0]     cursor_r, cursor_nxt;
  logic [CW-1:0]     col_r,    col_nxt;
  logic [LW-1:0]     line_r,   line_nxt;
  logic [SW-1:0]     sweep_r,  sweep_nxt;
  logic              scr_r,    scr_nxt;
  logic [ATTR_W-1:0] attr_r,   attr_nxt;
  logic              ovalid_r, ovalid_nxt;
  logic [OUT_DW-1:0] odata_r,  odata_nxt;

  logic [AW-1:0]     row_base;
  logic [CELL_W-1:0] blank_cell;
  logic [CELL_W-1:0] char_cell;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [CELL_W-1:0] wr_data;
  logic [AW-1:0]     rd_addr;
  logic [CELL_W-1:0] rd_data;
  logic              copy_phase;
  logic              rd_hit;
  logic [CELL_W-1:0] rd_word;

  assign row_base   = AW'(32'(line_r) * COLUMNS);
  assign blank_cell = {attr_r, CH_NULL};
  assign char_cell  = {attr_r, ch_r};
  // rows move up while the sweep is still inside the upper part
  assign copy_phase = sweep_r <= SW'(CELLS - COLUMNS);

  assign sts.is_put       = kind_r == KIND_PUT;
  assign sts.is_clear     = kind_r == KIND_CLEAR;
  assign sts.is_bs        = ch_r == CH_BACKSPACE;
  assign sts.is_nl        = ch_r == CH_NEWLINE;
  assign sts.is_null      = ch_r == CH_NULL;
  assign sts.cursor_zero  = cursor_r == '0;
  assign sts.col_last     = col_r == COL_LAST;
  assign sts.line_lt_rows = line_r < LW'(ROWS);
  assign sts.fill_last    = sweep_r == SW'(CELLS - 1);
  assign sts.scroll_last  = sweep_r == SW'(CELLS);
  assign sts.out_free     = !ovalid_r || out_tready;

  // store write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cursor_r;
    wr_data = blank_cell;
    case (cmd.op)
      OP_BACKSPACE: begin
        wr_en   = 1'b1;
        wr_addr = cursor_r - AW'(1);
      end
      OP_WRAP_PUT: begin
        wr_en   = 1'b1;
        wr_addr = row_base;
        wr_data = char_cell;
      end
      OP_PUT: begin
        wr_en   = 1'b1;
        wr_data = char_cell;
      end
      OP_SCROLL_STEP: begin
        wr_en   = sweep_r != '0;
        wr_addr = AW'(sweep_r - SW'(1));
        wr_data = copy_phase ? rd_data : blank_cell;
      end
      OP_FILL_STEP: begin
        wr_en   = 1'b1;
        wr_addr = AW'(sweep_r);
      end
      OP_INIT_STEP: begin
        wr_en   = 1'b1;
        wr_addr = AW'(sweep_r);
        wr_data = {RESET_ATTR, CH_NULL};
      end
      default: wr_en = 1'b0;
    endcase
  end

  // read one row ahead during a scroll, else hold the item address
  assign rd_addr = (cmd.op == OP_SCROLL_STEP) ? AW'(32'(sweep_r) + COLUMNS) : addr_r;

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_hit  = (kind_r == KIND_READ) && (32'(addr_r) < CELLS);
  assign rd_word = rd_hit ? rd_data : '0;

  always_comb begin
    kind_nxt   = kind_r;
    ch_nxt     = ch_r;
    addr_nxt   = addr_r;
    cursor_nxt = cursor_r;
    col_nxt    = col_r;
    line_nxt   = line_r;
    sweep_nxt  = sweep_r;
    scr_nxt    = scr_r;
    attr_nxt   = cfg_we ? cfg_attr : attr_r;

    if (cmd.latch) begin
      kind_nxt = in_kind;
      ch_nxt   = in_char;
      addr_nxt = in_addr;
      scr_nxt  = 1'b0;
    end

    case (cmd.op)
      OP_BACKSPACE: begin
        cursor_nxt = cursor_r - AW'(1);
        if (col_r == '0) begin
          col_nxt = COL_LAST;
          if (line_r != '0) line_nxt = line_r - LW'(1);
        end else begin
          col_nxt = col_r - CW'(1);
        end
      end
      OP_NEWLINE: begin
        cursor_nxt = row_base;
        col_nxt    = '0;
        line_nxt   = line_r + LW'(1);
      end
      OP_WRAP_PUT: begin
        cursor_nxt = row_base + AW'(1);
        col_nxt    = CW'(1);
        line_nxt   = line_r + LW'(1);
      end
      OP_PUT: begin
        cursor_nxt = cursor_r + AW'(1);
        col_nxt    = col_r + CW'(1);
      end
      OP_SCROLL_BEGIN: begin
        sweep_nxt  = '0;
        cursor_nxt = LAST_ROW;
        col_nxt    = '0;
        scr_nxt    = 1'b1;
      end
      OP_FILL_BEGIN: begin
        sweep_nxt  = '0;
        cursor_nxt = '0;
        col_nxt    = '0;
        line_nxt   = LW'(1);
      end
      OP_SCROLL_STEP, OP_FILL_STEP, OP_INIT_STEP: begin
        sweep_nxt = sweep_r + SW'(1);
      end
      default: sweep_nxt = sweep_r;
    endcase
  end

  // result stage: hold until the transfer completes
  always_comb begin
    ovalid_nxt = ovalid_r && !out_tready;
    odata_nxt  = odata_r;
    if (cmd.load_out) begin
      ovalid_nxt = 1'b1;
      odata_nxt  = OUT_DW'({rd_word[15:8], rd_word[7:0], scr_r, line_r, cursor_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
      col_r    <= '0;
      line_r   <= LW'(1);
      sweep_r  <= '0;
      scr_r    <= 1'b0;
      attr_r   <= RESET_ATTR;
      ovalid_r <= 1'b0;
    end else begin
      cursor_r <= cursor_nxt;
      col_r    <= col_nxt;
      line_r   <= line_nxt;
      sweep_r  <= sweep_nxt;
      scr_r    <= scr_nxt;
      attr_r   <= attr_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    ch_r    <= ch_nxt;
    addr_r  <= addr_nxt;
    odata_r <= odata_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

endmodule
`default_nettype wire

@@ rtl/text_console_cell_writer.sv @@
// ----------------------------------------------------------------------------
// text_console_cell_writer: teletype-style writer over a character-cell store
// Put, read and no-op items pass ST_DECODE and ST_RESULT; the next item may be
// taken in ST_RESULT as the result is loaded. A newline scroll sweeps the whole
// store (one cell per store port cycle), a scrolling wrap adds a put, clear fills it.
// Reset: clearing pass over the whole store with in_tready low; cfg open.
// ----------------------------------------------------------------------------
`default_nettype none
module text_console_cell_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  localparam int CELLS  = COLUMNS * ROWS,
  localparam int AW     = $clog2(CELLS),
  localparam int LW     = $clog2(ROWS + 1),
  localparam int IN_DW  = ((8 + AW) + 7) / 8 * 8,
  localparam int OUT_DW = ((AW + LW + 17) + 7) / 8 * 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [IN_DW-1:0]  in_tdata,   // char_code, cell_addr
  input  wire logic [1:0]        in_tuser,   // kind
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [OUT_DW-1:0]      out_tdata,  // cursor_cell, line_count, scrolled,
                                             // read_char, read_attr
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [7:0]        cfg_data    // text_attribute
);

  import tcw_pkg::*;

  tcw_cmd_t    cmd;
  tcw_status_t sts;

  assign cfg_ready = 1'b1;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_kind    (in_tuser),
    .in_char    (in_tdata[7:0]),
    .in_addr    (in_tdata[8 +: AW]),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_attr   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

@@ rtl/tcw_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console cell writer, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  localparam int CELLS  = COLUMNS * ROWS,
  localparam int AW     = $clog2(CELLS),
  localparam int LW     = $clog2(ROWS + 1),
  localparam int OUT_DW = ((AW + LW + 17) + 7) / 8 * 8
) (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_tvalid,
  input wire logic              in_tready,
  input wire logic              out_tvalid,
  input wire logic              out_tready,
  input wire logic [OUT_DW-1:0] out_tdata
);

  logic [AW-1:0] cursor;
  logic [LW-1:0] line;
  logic          scrolled;

  assign cursor   = out_tdata[AW-1:0];
  assign line     = out_tdata[AW +: LW];
  assign scrolled = out_tdata[AW + LW];

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // an accepted item keeps in_tready low in the cycle after the transfer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after a transfer");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> 32'(cursor) < CELLS)
    else $error("cursor beyond the store");

  a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> 32'(line) <= ROWS)
    else $error("line counter beyond the row count");

  // a scroll leaves the cursor on the bottom row with the counter at the end
  a_scroll_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && scrolled |->
      (32'(cursor) == CELLS - COLUMNS || 32'(cursor) == CELLS - COLUMNS + 1) &&
      32'(line) == ROWS)
    else $error("scroll left cursor or counter off the bottom row");

endmodule

bind text_console_cell_writer tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
